/* hdl/assert_macros.svh */
// Assertion macros used by the top level of the frame outcome stamper.
// Depends on a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside of reset.
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* hdl/fos_pkg.sv */
// Types, codes and constants of the frame outcome stamper.
// Used by fos_front, fos_back and the top level; depends on nothing else.
`default_nettype none

package fos_pkg;

  localparam int unsigned CfgIdxW = 8;

  typedef enum logic [1:0] {
    OUT_RECEIVED   = 2'd0,
    OUT_TIMEOUT    = 2'd1,
    OUT_INCOMPLETE = 2'd2,
    OUT_DROPPED    = 2'd3
  } outcome_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FIRST_ID     = 8'd0,
    REG_PERIOD       = 8'd1,
    REG_DEFAULT_SIZE = 8'd2,
    REG_START        = 8'd3
  } cfg_reg_e;

  localparam logic [31:0] FirstIdReset     = 32'd0;
  localparam logic [31:0] PeriodReset      = 32'd33333333;
  localparam logic [31:0] DefaultSizeReset = 32'd1;
  localparam logic [63:0] StartReset       = 64'd0;
  localparam logic [63:0] StampBumpNs      = 64'd1000;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [31:0] reported_size;
    logic [15:0] stall_count;
  } in_item_t;

  typedef struct packed {
    logic [31:0] frame_number;
    logic [63:0] stamp_ns;
    logic [31:0] frame_bytes;
    logic        is_dropped;
    logic [1:0]  event_kind;
    logic [31:0] count_received;
    logic [31:0] count_dropped;
    logic [31:0] count_timeout;
    logic [31:0] count_incomplete;
    logic [31:0] stall_sum;
  } out_item_t;

  // Classified item handed from the front part to the timestamp pipeline.
  typedef struct packed {
    logic [31:0] frame_number;
    logic [31:0] frame_bytes;
    logic [1:0]  event_kind;
    logic [31:0] count_received;
    logic [31:0] count_dropped;
    logic [31:0] count_timeout;
    logic [31:0] count_incomplete;
    logic [31:0] stall_sum;
  } mid_item_t;

  typedef struct packed {
    logic               valid;
    logic [CfgIdxW-1:0] index;
    logic [63:0]        data;
  } cfg_wr_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

endpackage

`default_nettype wire

/* hdl/fos_fifo.sv */
// Small register-based first-in first-out queue of generic width and depth.
// Depends on nothing else.
`default_nettype none

module fos_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* hdl/fos_front.sv */
// Front part: numbers and classifies each frame report and keeps the counters.
// Depends on fos_pkg.
`default_nettype none

module fos_front import fos_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cfg_wr_t   cfg_i,
  input  wire logic      push_i,
  input  wire in_item_t  in_item_i,
  input  wire logic      mid_full_i,
  output logic           mid_push_o,
  output mid_item_t      mid_item_o
);

  logic [31:0] first_id_q, first_id_d;
  logic [31:0] def_size_q, def_size_d;
  logic [31:0] next_id_q, next_id_d;
  logic [31:0] stall_q, stall_d;
  logic [31:0] rcv_q, rcv_d;
  logic [31:0] drp_q, drp_d;
  logic [31:0] tmo_q, tmo_d;
  logic [31:0] inc_q, inc_d;
  logic [32:0] stall_sum;
  logic [31:0] quarter;
  logic [31:0] bytes;
  logic        accept;

  assign accept = push_i && !mid_full_i;

  always_comb begin
    first_id_d = first_id_q;
    def_size_d = def_size_q;
    next_id_d  = next_id_q;
    stall_d    = stall_q;
    rcv_d      = rcv_q;
    drp_d      = drp_q;
    tmo_d      = tmo_q;
    inc_d      = inc_q;
    bytes      = '0;
    stall_sum  = {1'b0, stall_q} + {17'b0, in_item_i.stall_count};
    quarter    = def_size_q >> 2;

    if (accept) begin
      stall_d   = stall_sum[32] ? '1 : stall_sum[31:0];
      next_id_d = next_id_q + 32'd1;
      case (outcome_e'(in_item_i.outcome))
        OUT_TIMEOUT: begin
          tmo_d = sat_inc(tmo_q);
          drp_d = sat_inc(drp_q);
        end
        OUT_INCOMPLETE: begin
          if (in_item_i.reported_size != '0) begin
            bytes = in_item_i.reported_size;
          end else begin
            bytes = (quarter == '0) ? 32'd1 : quarter;
          end
          inc_d = sat_inc(inc_q);
          drp_d = sat_inc(drp_q);
        end
        OUT_DROPPED: begin
          drp_d = sat_inc(drp_q);
        end
        OUT_RECEIVED: begin
          bytes = (in_item_i.reported_size != '0) ? in_item_i.reported_size : def_size_q;
          rcv_d = sat_inc(rcv_q);
        end
        default: begin
          bytes = '0;
        end
      endcase
    end

    if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_FIRST_ID: begin
          first_id_d = cfg_i.data[31:0];
          next_id_d  = cfg_i.data[31:0];
        end
        REG_DEFAULT_SIZE: begin
          def_size_d = cfg_i.data[31:0];
        end
        default: begin
          def_size_d = def_size_q;
        end
      endcase
    end
  end

  always_comb begin
    mid_push_o                  = accept;
    mid_item_o.frame_number     = next_id_q;
    mid_item_o.frame_bytes      = bytes;
    mid_item_o.event_kind       = in_item_i.outcome;
    mid_item_o.count_received   = rcv_d;
    mid_item_o.count_dropped    = drp_d;
    mid_item_o.count_timeout    = tmo_d;
    mid_item_o.count_incomplete = inc_d;
    mid_item_o.stall_sum        = stall_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_id_q <= FirstIdReset;
      def_size_q <= DefaultSizeReset;
      next_id_q  <= FirstIdReset;
      stall_q    <= '0;
      rcv_q      <= '0;
      drp_q      <= '0;
      tmo_q      <= '0;
      inc_q      <= '0;
    end else begin
      first_id_q <= first_id_d;
      def_size_q <= def_size_d;
      next_id_q  <= next_id_d;
      stall_q    <= stall_d;
      rcv_q      <= rcv_d;
      drp_q      <= drp_d;
      tmo_q      <= tmo_d;
      inc_q      <= inc_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/fos_back.sv */
// Back part: three-stage timestamp pipeline and the strictly increasing stamp rule.
// Depends on fos_pkg.
`default_nettype none

module fos_back import fos_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cfg_wr_t   cfg_i,
  input  wire logic      mid_empty_i,
  input  wire mid_item_t mid_item_i,
  output logic           mid_pop_o,
  input  wire logic      out_full_i,
  output logic           out_push_o,
  output out_item_t      out_item_o
);

  logic [31:0] period_q, period_d;
  logic [63:0] start_q, start_d;
  logic [63:0] last_q;
  logic        have_last_q;

  logic        s1_v_q, s2_v_q, s3_v_q;
  mid_item_t   s1_item_q, s2_item_q, s3_item_q;
  logic [32:0] s1_factor_q;
  logic [63:0] s2_prod_q;
  logic [63:0] s3_raw_q;
  logic [64:0] prod_full;
  logic        en1, en2, en3;
  logic [63:0] stamp;

  assign out_push_o = s3_v_q && !out_full_i;
  assign en3        = !s3_v_q || out_push_o;
  assign en2        = !s2_v_q || en3;
  assign en1        = !s1_v_q || en2;
  assign mid_pop_o  = !mid_empty_i && en1;
  assign prod_full  = period_q * s1_factor_q;

  always_comb begin
    stamp = s3_raw_q;
    if (have_last_q && (s3_raw_q <= last_q)) begin
      stamp = last_q + StampBumpNs;
    end
  end

  always_comb begin
    out_item_o.frame_number     = s3_item_q.frame_number;
    out_item_o.stamp_ns         = stamp;
    out_item_o.frame_bytes      = s3_item_q.frame_bytes;
    out_item_o.is_dropped       = (s3_item_q.event_kind != OUT_RECEIVED);
    out_item_o.event_kind       = s3_item_q.event_kind;
    out_item_o.count_received   = s3_item_q.count_received;
    out_item_o.count_dropped    = s3_item_q.count_dropped;
    out_item_o.count_timeout    = s3_item_q.count_timeout;
    out_item_o.count_incomplete = s3_item_q.count_incomplete;
    out_item_o.stall_sum        = s3_item_q.stall_sum;
  end

  always_comb begin
    period_d = period_q;
    start_d  = start_q;
    if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_PERIOD: begin
          period_d = cfg_i.data[31:0];
        end
        REG_START: begin
          start_d = cfg_i.data;
        end
        default: begin
          period_d = period_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= PeriodReset;
      start_q     <= StartReset;
      last_q      <= '0;
      have_last_q <= 1'b0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
    end else begin
      period_q <= period_d;
      start_q  <= start_d;
      if (out_push_o) begin
        last_q      <= stamp;
        have_last_q <= 1'b1;
      end
      if (en1) begin
        s1_v_q <= !mid_empty_i;
      end
      if (en2) begin
        s2_v_q <= s1_v_q;
      end
      if (en3) begin
        s3_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_pop_o) begin
      s1_item_q   <= mid_item_i;
      s1_factor_q <= {1'b0, mid_item_i.frame_number} + {1'b0, mid_item_i.stall_sum};
    end
    if (en2 && s1_v_q) begin
      s2_item_q <= s1_item_q;
      s2_prod_q <= prod_full[63:0];
    end
    if (en3 && s2_v_q) begin
      s3_item_q <= s2_item_q;
      s3_raw_q  <= start_q + s2_prod_q;
    end
  end

endmodule

`default_nettype wire

/* hdl/frame_outcome_stamper.sv */
// Top level of the frame outcome stamper: front part, middle queue, back pipeline
// and result queue. Depends on fos_pkg, fos_fifo, fos_front, fos_back, assert_macros.svh.
//
//   Channel   Direction  Handshake                 Payload
//   input     in         push / full               in_item_i  (in_item_t)
//   result    out        empty / pop               out_item_o (out_item_t)
//   config    in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One item is accepted per cycle while full is low; an accepted item passes through
// the middle queue and three pipeline stages into the result queue. The timestamp
// product is registered in stage two; the previous-stamp compare acts on stage three.
// Reset clears all counters, the stamp history and both queues.
// A stalled result side fills the result queue, then the pipeline, then the middle
// queue, after which full is raised; configuration writes are always taken.
`default_nettype none

module frame_outcome_stamper import fos_pkg::*; #(
  parameter int unsigned MID_DEPTH = 2,
  parameter int unsigned OUT_DEPTH = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire in_item_t           in_item_i,
  output logic                    empty,
  input  wire logic               pop,
  output out_item_t               out_item_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [63:0]        cfg_data_i
);

  `include "assert_macros.svh"

  cfg_wr_t   cfg;
  logic      mid_push, mid_full, mid_pop, mid_empty;
  mid_item_t mid_in, mid_out;
  logic      out_push, out_full;
  out_item_t out_in;

  assign cfg_ready_o = 1'b1;
  assign cfg.valid   = cfg_valid_i;
  assign cfg.index   = cfg_index_i;
  assign cfg.data    = cfg_data_i;
  assign full        = mid_full;

  fos_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .push_i     (push),
    .in_item_i  (in_item_i),
    .mid_full_i (mid_full),
    .mid_push_o (mid_push),
    .mid_item_o (mid_in)
  );

  fos_fifo #(
    .WIDTH ($bits(mid_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_out),
    .empty_o (mid_empty)
  );

  fos_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .mid_empty_i (mid_empty),
    .mid_item_i  (mid_out),
    .mid_pop_o   (mid_pop),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .out_item_o  (out_in)
  );

  fos_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_in),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .empty_o (empty)
  );

  `ASSERT_ALL(a_no_push_when_full, out_push |-> !out_full, "result pushed into a full queue")
  `ASSERT_ALL(a_no_pop_when_empty, mid_pop |-> !mid_empty, "middle queue popped while empty")
  `ASSERT_RST(a_result_held, (!empty && !pop) |=> !empty, "waiting result vanished")

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench of frame_outcome_stamper: random and directed frame reports
// are pushed, and every result is checked against a predictor of ids, stamps and counters.
// Depends on fos_pkg and the frame_outcome_stamper RTL only.
module tb import fos_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CfgIdxW-1:0] RegSpare = '1;

  class stamp_tracker;
    logic [31:0] period_ns;
    logic [31:0] default_bytes;
    logic [63:0] start_ns;
    logic [31:0] next_id;
    logic [31:0] stall_total;
    logic [63:0] last_stamp;
    bit          have_last;
    logic [31:0] received_n;
    logic [31:0] dropped_n;
    logic [31:0] timeout_n;
    logic [31:0] incomplete_n;
    out_item_t   stamps_due[$];
    int unsigned mismatches;
    int unsigned stamps_checked;

    function new();
      period_ns     = PeriodReset;
      default_bytes = DefaultSizeReset;
      start_ns      = StartReset;
      next_id       = FirstIdReset;
      stall_total   = '0;
      last_stamp    = '0;
      have_last     = 1'b0;
      received_n    = '0;
      dropped_n     = '0;
      timeout_n     = '0;
      incomplete_n  = '0;
      mismatches    = 0;
      stamps_checked = 0;
    endfunction

    function logic [31:0] count_up(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] data);
      case (idx)
        REG_FIRST_ID:     next_id = data[31:0];
        REG_PERIOD:       period_ns = data[31:0];
        REG_DEFAULT_SIZE: default_bytes = data[31:0];
        REG_START:        start_ns = data;
        default: ;
      endcase
    endfunction

    function void note_report(in_item_t rep);
      logic [32:0] stall_acc;
      logic [63:0] stamp;
      logic [31:0] quarter;
      out_item_t   res;
      res = '0;
      stall_acc = {1'b0, stall_total} + {17'd0, rep.stall_count};
      stall_total = stall_acc[32] ? 32'hFFFF_FFFF : stall_acc[31:0];
      stamp = start_ns + {32'd0, period_ns} * ({32'd0, next_id} + {32'd0, stall_total});
      if (have_last && stamp <= last_stamp) begin
        stamp = last_stamp + StampBumpNs;
      end
      last_stamp = stamp;
      have_last = 1'b1;
      case (outcome_e'(rep.outcome))
        OUT_TIMEOUT: begin
          res.frame_bytes = '0;
          timeout_n = count_up(timeout_n);
          dropped_n = count_up(dropped_n);
        end
        OUT_INCOMPLETE: begin
          quarter = default_bytes >> 2;
          if (rep.reported_size != '0) begin
            res.frame_bytes = rep.reported_size;
          end else begin
            res.frame_bytes = (quarter == '0) ? 32'd1 : quarter;
          end
          incomplete_n = count_up(incomplete_n);
          dropped_n = count_up(dropped_n);
        end
        OUT_DROPPED: begin
          res.frame_bytes = '0;
          dropped_n = count_up(dropped_n);
        end
        default: begin
          res.frame_bytes = (rep.reported_size != '0) ? rep.reported_size : default_bytes;
          received_n = count_up(received_n);
        end
      endcase
      res.frame_number     = next_id;
      res.stamp_ns         = stamp;
      res.is_dropped       = (outcome_e'(rep.outcome) != OUT_RECEIVED);
      res.event_kind       = rep.outcome;
      res.count_received   = received_n;
      res.count_dropped    = dropped_n;
      res.count_timeout    = timeout_n;
      res.count_incomplete = incomplete_n;
      res.stall_sum        = stall_total;
      next_id = next_id + 32'd1;
      stamps_due = {stamps_due, res};
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_stamp(out_item_t got);
      out_item_t want;
      if (stamps_due.size() == 0) begin
        $error("result with no item waiting: frame_number %0h", got.frame_number);
        mismatches++;
        return;
      end
      want = stamps_due.pop_front();
      stamps_checked++;
      compare_field("frame_number", want.frame_number, got.frame_number);
      compare_field("stamp_ns", want.stamp_ns, got.stamp_ns);
      compare_field("frame_bytes", want.frame_bytes, got.frame_bytes);
      compare_field("is_dropped", want.is_dropped, got.is_dropped);
      compare_field("event_kind", want.event_kind, got.event_kind);
      compare_field("count_received", want.count_received, got.count_received);
      compare_field("count_dropped", want.count_dropped, got.count_dropped);
      compare_field("count_timeout", want.count_timeout, got.count_timeout);
      compare_field("count_incomplete", want.count_incomplete, got.count_incomplete);
      compare_field("stall_sum", want.stall_sum, got.stall_sum);
    endfunction

    function int unsigned pending();
      return stamps_due.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               push;
  logic               full;
  in_item_t           frame_report;
  logic               empty;
  logic               pop;
  out_item_t          frame_stamp;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [63:0]        cfg_data;

  stamp_tracker tracker;
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;
  int unsigned  reports_sent;
  int unsigned  regs_written;

  frame_outcome_stamper u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (frame_report),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (frame_stamp),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        tracker.check_stamp(frame_stamp);
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #4ms;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic in_item_t make_report(outcome_e kind, logic [31:0] size,
                                           logic [15:0] stall);
    in_item_t rep;
    rep.outcome       = kind;
    rep.reported_size = size;
    rep.stall_count   = stall;
    return rep;
  endfunction

  function automatic in_item_t random_report();
    in_item_t rep;
    rep.outcome = 2'($urandom_range(3));
    case ($urandom_range(7))
      0:       rep.reported_size = '0;
      1:       rep.reported_size = '1;
      default: rep.reported_size = $urandom;
    endcase
    case ($urandom_range(7))
      0, 1, 2: rep.stall_count = '0;
      3:       rep.stall_count = '1;
      4, 5:    rep.stall_count = 16'($urandom_range(1, 8));
      default: rep.stall_count = 16'($urandom_range(65535));
    endcase
    return rep;
  endfunction

  task automatic send_report(input in_item_t rep);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    frame_report <= rep;
    do @(posedge clk_i); while (full);
    tracker.note_report(rep);
    reports_sent++;
  endtask

  task automatic drain();
    push <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() != 0);
  endtask

  // The write strobe stays high across back-to-back writes and drops after the last one.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] data,
                           input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready);
    tracker.write_reg(idx, data);
    regs_written++;
    if (last) begin
      cfg_valid <= 1'b0;
    end
  endtask

  task automatic configure(input logic [31:0] first_id, input logic [31:0] period,
                           input logic [31:0] dflt, input logic [63:0] start);
    write_reg(REG_FIRST_ID, {32'd0, first_id}, 1'b0);
    write_reg(REG_PERIOD, {32'd0, period}, 1'b0);
    write_reg(REG_DEFAULT_SIZE, {32'd0, dflt}, 1'b0);
    write_reg(REG_START, start, 1'b1);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned stall_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  initial begin
    tracker = new();
    rst_ni = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    frame_report = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    reports_sent = 0;
    regs_written = 0;
    set_idling(0, 0);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_report(make_report(OUT_RECEIVED, 32'd0, 16'd0));
    send_report(make_report(OUT_RECEIVED, '1, '1));
    send_report(make_report(OUT_TIMEOUT, 32'h5555_AAAA, 16'd0));
    send_report(make_report(OUT_INCOMPLETE, 32'd0, 16'd1));
    send_report(make_report(OUT_INCOMPLETE, 32'hAAAA_5555, 16'h5555));
    send_report(make_report(OUT_DROPPED, '1, 16'hAAAA));
    drain();
    write_reg(REG_DEFAULT_SIZE, 64'd0, 1'b0);
    write_reg(RegSpare, '1, 1'b1);
    send_report(make_report(OUT_RECEIVED, 32'd0, 16'd0));
    send_report(make_report(OUT_INCOMPLETE, 32'd0, 16'd0));
    drain();
    write_reg(REG_DEFAULT_SIZE, 64'hFFFF_FFFF, 1'b1);
    send_report(make_report(OUT_INCOMPLETE, 32'd0, 16'd0));
    send_report(make_report(OUT_RECEIVED, 32'd0, 16'd0));
    drain();
    write_reg(REG_FIRST_ID, 64'hFFFF_FFFE, 1'b1);
    repeat (3) send_report(make_report(OUT_RECEIVED, 32'd100, 16'd0));
    drain();
    write_reg(REG_PERIOD, 64'd0, 1'b0);
    write_reg(REG_START, 64'hFFFF_FFFF_FFFF_FE00, 1'b1);
    repeat (4) send_report(make_report(OUT_DROPPED, 32'd7, 16'd3));
    drain();
    write_reg(REG_PERIOD, 64'hFFFF_FFFF, 1'b0);
    write_reg(REG_START, '1, 1'b1);
    repeat (2) send_report(make_report(OUT_TIMEOUT, 32'd0, '1));
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: configure(32'd0, 32'd1, 32'd1, 64'd0);
        1: configure('1, '1, '1, '1);
        2: configure($urandom, $urandom_range(1, 100000), $urandom, {$urandom, $urandom});
        3: configure($urandom, 32'd33333333, 32'd4, {32'd0, $urandom});
        4: configure(32'hFFFF_FFC0, $urandom_range(1, 1000), $urandom_range(0, 3), 64'd0);
        default: configure($urandom, $urandom, $urandom, {$urandom, $urandom});
      endcase
      case (phase % 4)
        0: set_idling(0, 0);
        1: set_idling(84, 0);
        2: set_idling(0, 84);
        default: set_idling(7, 7);
      endcase
      for (int n = 0; n < 190; n++) begin
        if (phase == 2 && n == 95) begin
          drain();
        end
        send_report(random_report());
      end
      drain();
    end

    // Closing burst at full rate with a small period and random reports.
    configure($urandom, 32'd3, $urandom, 64'd0);
    set_idling(0, 0);
    repeat (20) send_report(random_report());
    drain();
    repeat (16) @(posedge clk_i);

    $display("Sent %0d frame reports over %0d register writes; checked %0d results.",
             reports_sent, regs_written, tracker.stamps_checked);
    $display("Covered id wrap, stamp bump and wrap, size defaults and large stall totals.");
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
